// ===== rtl/core/pvni_pkg.sv =====
// Shared types, codes and the stencil offset table for the periodic neighbour indexer.
`default_nettype none

package pvni_pkg;

    localparam int COORD_W = 10;
    localparam int EXT_W   = 11;
    localparam int IDX_W   = 30;
    localparam int SLOT_W  = 5;
    localparam int K_W     = 5;
    localparam int PROD_W  = 2 * EXT_W;

    // stencil positions of the final word in each mode
    localparam logic [K_W-1:0] K_LAST_FULL    = 5'd26;
    localparam logic [K_W-1:0] K_LAST_REDUCED = 5'd25;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_EXTENT_X     = 2'd0,
        CFG_EXTENT_Y     = 2'd1,
        CFG_EXTENT_Z     = 2'd2,
        CFG_STENCIL_MODE = 2'd3
    } t_cfg_addr;

    typedef enum logic [1:0] {
        OFS_ZERO = 2'd0,
        OFS_DEC  = 2'd1,
        OFS_INC  = 2'd2
    } t_ofs;

    typedef struct packed {
        t_ofs dx;
        t_ofs dy;
        t_ofs dz;
    } t_ofs3;

    typedef struct packed {
        logic [EXT_W-1:0] ex;
        logic [EXT_W-1:0] ey;
        logic [EXT_W-1:0] ez;
    } t_ext;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_meta;

    // one stencil position issued by the sequencer
    typedef struct packed {
        logic                valid;
        logic [K_W-1:0]      k;
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [COORD_W-1:0]  cz;
        t_meta               meta;
    } t_issue;

    function automatic t_ofs3 stencil_ofs(input logic [K_W-1:0] k);
        t_ofs3 o;
        case (k)
            5'd0:  o = '{OFS_ZERO, OFS_ZERO, OFS_ZERO};
            5'd1:  o = '{OFS_DEC,  OFS_DEC,  OFS_DEC};
            5'd2:  o = '{OFS_ZERO, OFS_DEC,  OFS_DEC};
            5'd3:  o = '{OFS_INC,  OFS_DEC,  OFS_DEC};
            5'd4:  o = '{OFS_DEC,  OFS_ZERO, OFS_DEC};
            5'd5:  o = '{OFS_ZERO, OFS_ZERO, OFS_DEC};
            5'd6:  o = '{OFS_INC,  OFS_ZERO, OFS_DEC};
            5'd7:  o = '{OFS_DEC,  OFS_INC,  OFS_DEC};
            5'd8:  o = '{OFS_ZERO, OFS_INC,  OFS_DEC};
            5'd9:  o = '{OFS_INC,  OFS_INC,  OFS_DEC};
            5'd10: o = '{OFS_DEC,  OFS_DEC,  OFS_ZERO};
            5'd11: o = '{OFS_ZERO, OFS_DEC,  OFS_ZERO};
            5'd12: o = '{OFS_INC,  OFS_DEC,  OFS_ZERO};
            5'd13: o = '{OFS_DEC,  OFS_ZERO, OFS_ZERO};
            5'd14: o = '{OFS_INC,  OFS_ZERO, OFS_ZERO};
            5'd15: o = '{OFS_DEC,  OFS_INC,  OFS_ZERO};
            5'd16: o = '{OFS_ZERO, OFS_INC,  OFS_ZERO};
            5'd17: o = '{OFS_INC,  OFS_INC,  OFS_ZERO};
            5'd18: o = '{OFS_DEC,  OFS_DEC,  OFS_INC};
            5'd19: o = '{OFS_ZERO, OFS_DEC,  OFS_INC};
            5'd20: o = '{OFS_INC,  OFS_DEC,  OFS_INC};
            5'd21: o = '{OFS_DEC,  OFS_ZERO, OFS_INC};
            5'd22: o = '{OFS_ZERO, OFS_ZERO, OFS_INC};
            5'd23: o = '{OFS_INC,  OFS_ZERO, OFS_INC};
            5'd24: o = '{OFS_DEC,  OFS_INC,  OFS_INC};
            5'd25: o = '{OFS_ZERO, OFS_INC,  OFS_INC};
            5'd26: o = '{OFS_INC,  OFS_INC,  OFS_INC};
            default: o = '{OFS_ZERO, OFS_ZERO, OFS_ZERO};
        endcase
        return o;
    endfunction

    function automatic logic is_corner(input logic [K_W-1:0] k);
        t_ofs3 o;
        o = stencil_ofs(k);
        return (o.dx != OFS_ZERO) && (o.dy != OFS_ZERO) && (o.dz != OFS_ZERO);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/periodic_voxel_neighbour_indexer_unit.sv =====
// Top level of the periodic voxel neighbour indexer: config registers, pipeline, output register.
//
//  channel   dir  handshake              payload
//  s_        in   i_s_tvalid/o_s_tready  tdata: centre_x, centre_y, centre_z
//  m_        out  o_m_tvalid/i_m_tready  tdata: neighbour_index, neighbour_slot; tlast
//  cfg       in   i_cfg_we               i_cfg_addr, i_cfg_data
//
// One index word per cycle while m_ does not stall: a centre gives 27 words in full mode and
// 19 in reduced mode, set by the stencil sequencer; the next centre is taken on the cycle of
// the last issue. The first word of a centre passes the sequencer, four arithmetic stages
// and the output register. Reset (synchronous, active low) empties the pipe and sets
// extents to 1 and full mode. A stall on m_ freezes the whole pipe in place.
`default_nettype none

module periodic_voxel_neighbour_indexer_unit #(
    parameter int MAX_EXTENT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [9:0] centre_x, [19:10] centre_y, [29:20] centre_z
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // [29:0] neighbour_index, [34:30] neighbour_slot
    output logic             o_m_tlast,   // last_neighbour
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [10:0] i_cfg_data
);

    localparam int EW = pvni_pkg::EXT_W;
    localparam int IW = pvni_pkg::IDX_W;
    localparam int SW = pvni_pkg::SLOT_W;

    function automatic logic [EW-1:0] eff_extent(input logic [EW-1:0] r);
        logic [EW-1:0] e;
        e = r;
        if (r == '0) begin
            e = EW'(1);
        end else if ({{(32-EW){1'b0}}, r} > 32'(MAX_EXTENT)) begin
            e = EW'(MAX_EXTENT);
        end
        return e;
    endfunction

    logic [EW-1:0]     r_ext_x, r_ext_y, r_ext_z;
    logic              r_mode;
    pvni_pkg::t_ext    ext;
    pvni_pkg::t_issue  issue;
    logic              en;
    logic              c_valid;
    logic [IW-1:0]     c_index;
    pvni_pkg::t_meta   c_meta;
    logic              r_out_valid;
    logic [IW-1:0]     r_out_index;
    pvni_pkg::t_meta   r_out_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_x <= EW'(1);
            r_ext_y <= EW'(1);
            r_ext_z <= EW'(1);
            r_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            case (pvni_pkg::t_cfg_addr'(i_cfg_addr))
                pvni_pkg::CFG_EXTENT_X:     r_ext_x <= i_cfg_data;
                pvni_pkg::CFG_EXTENT_Y:     r_ext_y <= i_cfg_data;
                pvni_pkg::CFG_EXTENT_Z:     r_ext_z <= i_cfg_data;
                pvni_pkg::CFG_STENCIL_MODE: r_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign ext.ex = eff_extent(r_ext_x);
    assign ext.ey = eff_extent(r_ext_y);
    assign ext.ez = eff_extent(r_ext_z);

    // whole pipe moves when the output register is free or being drained
    assign en = !r_out_valid || i_m_tready;

    pvni_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_mode  (r_mode),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_cx    (i_s_tdata[9:0]),
        .i_cy    (i_s_tdata[19:10]),
        .i_cz    (i_s_tdata[29:20]),
        .o_issue (issue)
    );

    pvni_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ext   (ext),
        .i_issue (issue),
        .o_valid (c_valid),
        .o_index (c_index),
        .o_meta  (c_meta)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_index <= c_index;
            r_out_meta  <= c_meta;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(40-IW-SW){1'b0}}, r_out_meta.slot, r_out_index};
    assign o_m_tlast  = r_out_meta.last;

endmodule

`default_nettype wire

// ===== rtl/core/pvni_seq.sv =====
// Input capture and stencil sequencer: walks one centre through its stencil positions.
`default_nettype none

module pvni_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_mode,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [pvni_pkg::COORD_W-1:0]  i_cx,
    input  wire logic [pvni_pkg::COORD_W-1:0]  i_cy,
    input  wire logic [pvni_pkg::COORD_W-1:0]  i_cz,
    output pvni_pkg::t_issue                   o_issue
);

    logic                          r_busy, n_busy;
    logic [pvni_pkg::K_W-1:0]      r_k, n_k;
    logic [pvni_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic [pvni_pkg::COORD_W-1:0]  r_cx, r_cy, r_cz;
    logic [pvni_pkg::K_W-1:0]      k_inc;
    logic                          at_last;
    logic                          take;

    assign at_last = i_mode ? (r_k == pvni_pkg::K_LAST_REDUCED)
                            : (r_k == pvni_pkg::K_LAST_FULL);
    assign o_ready = i_en && (!r_busy || at_last);
    assign take    = i_valid && o_ready;
    assign k_inc   = r_k + pvni_pkg::K_W'(1);

    always_comb begin
        n_busy = r_busy;
        n_k    = r_k;
        n_slot = r_slot;
        if (take) begin
            n_busy = 1'b1;
            n_k    = '0;
            n_slot = '0;
        end else if (i_en && r_busy) begin
            if (at_last) begin
                n_busy = 1'b0;
            end else begin
                // reduced stencil skips corners; no two corners are adjacent
                n_k    = (i_mode && pvni_pkg::is_corner(k_inc)) ?
                         r_k + pvni_pkg::K_W'(2) : k_inc;
                n_slot = r_slot + pvni_pkg::SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_slot <= '0;
        end else begin
            r_busy <= n_busy;
            r_k    <= n_k;
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cx <= i_cx;
            r_cy <= i_cy;
            r_cz <= i_cz;
        end
    end

    assign o_issue.valid     = r_busy;
    assign o_issue.k         = r_k;
    assign o_issue.cx        = r_cx;
    assign o_issue.cy        = r_cy;
    assign o_issue.cz        = r_cz;
    assign o_issue.meta.slot = r_slot;
    assign o_issue.meta.last = at_last;

endmodule

`default_nettype wire

// ===== rtl/core/pvni_calc.sv =====
// Four-stage index pipeline: wrap coordinates, partial products, full product, final sum.
`default_nettype none

module pvni_calc (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  pvni_pkg::t_ext                   i_ext,
    input  pvni_pkg::t_issue                 i_issue,
    output logic                             o_valid,
    output logic [pvni_pkg::IDX_W-1:0]       o_index,
    output pvni_pkg::t_meta                  o_meta
);

    localparam int EW = pvni_pkg::EXT_W;
    localparam int PW = pvni_pkg::PROD_W;
    localparam int IW = pvni_pkg::IDX_W;

    function automatic logic [EW-1:0] step(input logic [EW-1:0] c,
                                           input pvni_pkg::t_ofs d,
                                           input logic [EW-1:0] e);
        logic [EW-1:0] em1;
        em1 = e - EW'(1);
        case (d)
            pvni_pkg::OFS_DEC: step = (c == '0) ? em1 : c - EW'(1);
            pvni_pkg::OFS_INC: step = (c == em1) ? '0 : c + EW'(1);
            default:           step = c;
        endcase
    endfunction

    pvni_pkg::t_ofs3      ofs;

    // stage A: wrapped neighbour coordinates
    logic                 r_a_valid;
    logic [EW-1:0]        r_a_nx, r_a_ny, r_a_nz;
    pvni_pkg::t_meta      r_a_meta;
    // stage B: y*Z and x*Y
    logic                 r_b_valid;
    logic [PW-1:0]        r_b_py, r_b_px;
    logic [EW-1:0]        r_b_nz;
    pvni_pkg::t_meta      r_b_meta;
    // stage C: z + y*Z and x*Y*Z
    logic                 r_c_valid;
    logic [PW:0]          r_c_t;
    logic [IW-1:0]        r_c_q;
    pvni_pkg::t_meta      r_c_meta;
    // stage D: final index
    logic                 r_d_valid;
    logic [IW-1:0]        r_d_idx;
    pvni_pkg::t_meta      r_d_meta;

    logic [PW+EW-1:0]     q_full;

    assign ofs    = pvni_pkg::stencil_ofs(i_issue.k);

    // x*Y*Z, 22 x 11 bits, low bits kept
    assign q_full = {{EW{1'b0}}, r_b_px} * {{PW{1'b0}}, i_ext.ez};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_issue.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_nx   <= step({1'b0, i_issue.cx}, ofs.dx, i_ext.ex);
            r_a_ny   <= step({1'b0, i_issue.cy}, ofs.dy, i_ext.ey);
            r_a_nz   <= step({1'b0, i_issue.cz}, ofs.dz, i_ext.ez);
            r_a_meta <= i_issue.meta;

            r_b_py   <= r_a_ny * i_ext.ez;
            r_b_px   <= r_a_nx * i_ext.ey;
            r_b_nz   <= r_a_nz;
            r_b_meta <= r_a_meta;

            r_c_t    <= {1'b0, r_b_py} + {{(PW+1-EW){1'b0}}, r_b_nz};
            r_c_q    <= q_full[IW-1:0];
            r_c_meta <= r_b_meta;

            r_d_idx  <= {{(IW-PW-1){1'b0}}, r_c_t} + r_c_q;
            r_d_meta <= r_c_meta;
        end
    end

    assign o_valid = r_d_valid;
    assign o_index = r_d_idx;
    assign o_meta  = r_d_meta;

endmodule

`default_nettype wire

// ===== bench/pvni_neighbour_checker.sv =====
// Scoreboard for the neighbour indexer: tracks config writes, predicts index words, compares.
`default_nettype none

module pvni_neighbour_checker #(
    parameter int MAX_EXTENT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [9:0] centre_x, [19:10] centre_y, [29:20] centre_z
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [39:0] i_m_tdata,   // [29:0] neighbour_index, [34:30] neighbour_slot
    input  wire logic        i_m_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [10:0] i_cfg_data,
    output int               o_pending,
    output int               o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW = pvni_pkg::IDX_W;
    localparam int SW = pvni_pkg::SLOT_W;
    localparam int EW = pvni_pkg::EXT_W;

    typedef struct packed {
        logic [IW-1:0] index;
        logic [SW-1:0] slot;
        logic          last;
    } t_neighbour_word;

    t_neighbour_word  expected_words[$];
    logic [EW-1:0]    ext_x_q = 11'd1;
    logic [EW-1:0]    ext_y_q = 11'd1;
    logic [EW-1:0]    ext_z_q = 11'd1;
    logic             reduced_q = 1'b0;
    int               mismatches = 0;
    int               pending_cnt = 0;

    assign o_pending  = pending_cnt;
    assign o_failures = mismatches;

    // zero acts as one, oversize saturates
    function automatic longint unsigned effective_extent(input logic [EW-1:0] r);
        if (r == '0)
            return 1;
        if (r > MAX_EXTENT)
            return MAX_EXTENT;
        return r;
    endfunction

    // periodic wrap only at exactly 0 and extent-1; out-of-grid centres step plainly
    function automatic longint unsigned wrap_step(input longint unsigned c, input int d,
                                                  input longint unsigned e);
        if (d < 0)
            return (c == 0) ? e - 1 : c - 1;
        if (d > 0)
            return (c == e - 1) ? 0 : c + 1;
        return c;
    endfunction

    task automatic queue_neighbour(input longint unsigned cx, input longint unsigned cy,
                                   input longint unsigned cz, input int dx, input int dy,
                                   input int dz, input int slot, input int total);
        longint unsigned ex, ey, ez, nx, ny, nz, idx;
        t_neighbour_word w;
        ex = effective_extent(ext_x_q);
        ey = effective_extent(ext_y_q);
        ez = effective_extent(ext_z_q);
        nx = wrap_step(cx, dx, ex);
        ny = wrap_step(cy, dy, ey);
        nz = wrap_step(cz, dz, ez);
        idx = nz + ny * ez + nx * ey * ez;
        w.index = idx[IW-1:0];
        w.slot  = slot[SW-1:0];
        w.last  = (slot == total - 1);
        expected_words.push_back(w);
    endtask

    // centre first, then planes z-1, z, z+1; y then x (fastest) inside each plane
    task automatic predict_neighbours(input logic [31:0] word);
        longint unsigned cx, cy, cz;
        int dx, dy, dz, slot, total;
        cx = word[9:0];
        cy = word[19:10];
        cz = word[29:20];
        total = reduced_q ? 19 : 27;
        queue_neighbour(cx, cy, cz, 0, 0, 0, 0, total);
        slot = 1;
        for (dz = -1; dz <= 1; dz++) begin
            for (dy = -1; dy <= 1; dy++) begin
                for (dx = -1; dx <= 1; dx++) begin
                    if (!(dx == 0 && dy == 0 && dz == 0) &&
                        !(reduced_q && dx != 0 && dy != 0 && dz != 0)) begin
                        queue_neighbour(cx, cy, cz, dx, dy, dz, slot, total);
                        slot++;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_neighbour_word want;
        if (!i_rst_n) begin
            ext_x_q   = 11'd1;
            ext_y_q   = 11'd1;
            ext_z_q   = 11'd1;
            reduced_q = 1'b0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (pvni_pkg::t_cfg_addr'(i_cfg_addr))
                    pvni_pkg::CFG_EXTENT_X:     ext_x_q   = i_cfg_data;
                    pvni_pkg::CFG_EXTENT_Y:     ext_y_q   = i_cfg_data;
                    pvni_pkg::CFG_EXTENT_Z:     ext_z_q   = i_cfg_data;
                    pvni_pkg::CFG_STENCIL_MODE: reduced_q = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                predict_neighbours(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: unexpected word idx=%0d slot=%0d last=%b", $realtime,
                                 i_m_tdata[IW-1:0], i_m_tdata[IW+SW-1:IW], i_m_tlast);
                end else begin
                    want = expected_words.pop_front();
                    if (i_m_tdata[IW-1:0] !== want.index ||
                        i_m_tdata[IW+SW-1:IW] !== want.slot ||
                        i_m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%t: idx/slot/last exp %0d/%0d/%b got %0d/%0d/%b",
                                     $realtime, want.index, want.slot, want.last,
                                     i_m_tdata[IW-1:0], i_m_tdata[IW+SW-1:IW],
                                     i_m_tlast);
                    end
                end
            end
        end
        pending_cnt = expected_words.size();
    end

endmodule

`default_nettype wire

// ===== bench/tb_periodic_voxel_neighbour_indexer_unit.sv =====
// Testbench top for the neighbour indexer: clock, reset, stimulus, watchdog and verdict.
`default_nettype none

module tb_periodic_voxel_neighbour_indexer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_EXTENT     = 1024;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 15;
    localparam int DRAIN_CYCLES   = 20;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata    = '0;   // [9:0] centre_x, [19:10] centre_y, [29:20] centre_z
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [39:0] m_tdata;           // [29:0] neighbour_index, [34:30] neighbour_slot
    logic        m_tlast;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_addr   = '0;
    logic [10:0] cfg_data   = '0;

    int          pending;
    int          failures;
    int          send_idle  = 0;
    int          recv_idle  = 0;
    bit          timed_out  = 1'b0;

    periodic_voxel_neighbour_indexer_unit #(
        .MAX_EXTENT(MAX_EXTENT)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tlast (m_tlast),
        .i_cfg_we  (cfg_we),
        .i_cfg_addr(cfg_addr),
        .i_cfg_data(cfg_data)
    );

    pvni_neighbour_checker #(
        .MAX_EXTENT(MAX_EXTENT)
    ) u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .i_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .i_m_tdata (m_tdata),
        .i_m_tlast (m_tlast),
        .i_cfg_we  (cfg_we),
        .i_cfg_addr(cfg_addr),
        .i_cfg_data(cfg_data),
        .o_pending (pending),
        .o_failures(failures)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle);

    task automatic set_idling(input int profile);
        case (profile)
            0: begin send_idle = 24; recv_idle = 85; end
            1: begin send_idle = 85; recv_idle = 24; end
            default: begin send_idle = 0; recv_idle = 0; end
        endcase
    endtask

    // hold off new centres until every predicted word has come out
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [10:0] ex, input logic [10:0] ey,
                                input logic [10:0] ez, input logic reduced);
        drain();
        cfg_we   = 1'b1;
        cfg_addr = pvni_pkg::CFG_EXTENT_X;
        cfg_data = ex;
        @(negedge i_clk);
        cfg_addr = pvni_pkg::CFG_EXTENT_Y;
        cfg_data = ey;
        @(negedge i_clk);
        cfg_addr = pvni_pkg::CFG_EXTENT_Z;
        cfg_data = ez;
        @(negedge i_clk);
        cfg_addr = pvni_pkg::CFG_STENCIL_MODE;
        cfg_data = {10'd0, reduced};
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    // valid stays high across back-to-back words; dropped only for idle gaps and drains
    task automatic send_centre(input logic [9:0] x, input logic [9:0] y, input logic [9:0] z);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, z, y, x};
        do
            @(posedge i_clk);
        while (!s_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [10:0] pick_extent();
        case ($urandom_range(0, 9))
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'(MAX_EXTENT);
            3: return 11'($urandom_range(MAX_EXTENT + 1, 2047));
            4, 5, 6: return 11'($urandom_range(2, 16));
            default: return 11'($urandom_range(1, MAX_EXTENT));
        endcase
    endfunction

    // mostly inside the grid with edges favored; some raw values land outside
    function automatic logic [9:0] pick_coord(input logic [10:0] ext);
        int lim;
        lim = (ext == 0) ? 1 : ((ext > MAX_EXTENT) ? MAX_EXTENT : int'(ext));
        case ($urandom_range(0, 9))
            0: return 10'd0;
            1: return 10'(lim - 1);
            2: return 10'($urandom_range(0, 1023));
            default: return 10'($urandom_range(0, lim - 1));
        endcase
    endfunction

    initial begin : main
        int idle_cycles;
        int ph, i;
        logic [10:0] ex, ey, ez;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        fork
            begin
                set_idling(0);
                // reset extents are 1: every nonzero centre is outside the grid
                send_centre(10'd0, 10'd0, 10'd0);
                send_centre(10'd1023, 10'd1023, 10'd1023);

                apply_config(11'd1024, 11'd1024, 11'd1024, 1'b0);
                send_centre(10'd0, 10'd0, 10'd0);
                send_centre(10'd1023, 10'd1023, 10'd1023);
                send_centre(10'd0, 10'd1023, 10'd512);
                send_centre(10'd512, 10'd0, 10'd1023);

                // zero extent and saturating extents, reduced stencil
                apply_config(11'd0, 11'd2047, 11'd1025, 1'b1);
                send_centre(10'd0, 10'd0, 10'd0);
                send_centre(10'd1023, 10'd1023, 10'd1023);
                send_centre(10'd5, 10'd1023, 10'd0);

                // x steps past extent to 1024: index overflows 30 bits
                apply_config(11'd2, 11'd1024, 11'd1024, 1'b0);
                send_centre(10'd1023, 10'd1023, 10'd1023);
                send_centre(10'd1, 10'd0, 10'd0);
                send_centre(10'd0, 10'd1023, 10'd1023);

                apply_config(11'd3, 11'd5, 11'd7, 1'b1);
                send_centre(10'd0, 10'd0, 10'd0);
                send_centre(10'd2, 10'd4, 10'd6);
                send_centre(10'd1, 10'd2, 10'd3);
                send_centre(10'd3, 10'd5, 10'd7);

                for (ph = 0; ph < RANDOM_PHASES; ph++) begin
                    ex = pick_extent();
                    ey = pick_extent();
                    ez = pick_extent();
                    apply_config(ex, ey, ez, 1'($urandom_range(0, 1)));
                    set_idling((ph < 4) ? 0 : ((ph < 7) ? 1 : 2));
                    for (i = 0; i < PHASE_ITEMS; i++) begin
                        if (ph == 8 && i == PHASE_ITEMS / 2)
                            drain();
                        if ($urandom_range(0, 4) == 0)
                            send_centre(10'($urandom_range(0, 1023)),
                                        10'($urandom_range(0, 1023)),
                                        10'($urandom_range(0, 1023)));
                        else
                            send_centre(pick_coord(ex), pick_coord(ey), pick_coord(ez));
                    end
                end

                drain();
                repeat (DRAIN_CYCLES) @(negedge i_clk);
            end
            begin
                idle_cycles = 0;
                while (idle_cycles < WATCHDOG_LIMIT) begin
                    @(posedge i_clk);
                    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                        idle_cycles = 0;
                    else
                        idle_cycles++;
                end
                timed_out = 1'b1;
                $display("%t: watchdog expired with %0d words outstanding", $realtime, pending);
            end
        join_any

        if (!timed_out && failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
